// ===== rtl/core/best_rational_approximation_assert.svh =====
// Assertion macros for the checker file of the rational approximation block.
`ifndef BEST_RATIONAL_APPROXIMATION_ASSERT_SVH
`define BEST_RATIONAL_APPROXIMATION_ASSERT_SVH

// Plain property check, switched off while reset is held.
`define BRA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Same-cycle implication, switched off while reset is held.
`define BRA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/bra_pkg.sv =====
// Shared types and constants of the rational approximation block.
package bra_pkg;

    // Default geometry of the number format and of the result denominator.
    localparam int unsigned FRAC_BITS_DEF  = 32;
    localparam int unsigned INT_BITS_DEF   = 15;
    localparam int unsigned DENOM_BITS_DEF = 16;

    // Fixed widths of the configuration registers, of the numerator and of the register port.
    localparam int unsigned MAXDEN_W = 16;
    localparam int unsigned TOL_W    = 32;
    localparam int unsigned NUM_W    = 32;
    localparam int unsigned APB_DW   = 32;
    localparam int unsigned APB_AW   = 3;

    localparam logic [MAXDEN_W-1:0] MAXDEN_RST = 16'd256;
    localparam logic [TOL_W-1:0]    TOL_RST    = 32'd4295;
    localparam logic [NUM_W-1:0]    NUM_MAX    = 32'h7FFF_FFFF;

    typedef enum logic [0:0] {
        REG_MAX_DEN = 1'b0,
        REG_TOL     = 1'b1
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SPLIT,
        ST_INIT,
        ST_WALK,
        ST_MULT,
        ST_ADD,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic capture;
        logic split;
        logic init;
        logic step;
        logic pick;
        logic mult;
        logic add_int;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic in_bounds;
        logic hit;
    } t_dp_sts;

endpackage

// ===== rtl/core/bra_regs.sv =====
// Configuration register file behind the APB-style port.
module bra_regs
    import bra_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_psel,
    input  logic                i_penable,
    input  logic                i_pwrite,
    input  logic [APB_AW-1:0]   i_paddr,
    input  logic [APB_DW-1:0]   i_pwdata,
    output logic [APB_DW-1:0]   o_prdata,
    output logic                o_pready,
    output logic [MAXDEN_W-1:0] o_max_den,
    output logic [TOL_W-1:0]    o_tol
);

    logic [MAXDEN_W-1:0] r_max_den;
    logic [TOL_W-1:0]    r_tol;
    logic                w_wr;
    t_reg_idx            w_idx;

    // Registers sit on word boundaries, so the byte offset bits are ignored.
    assign w_idx = t_reg_idx'(i_paddr[APB_AW-1]);
    assign w_wr  = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_den <= MAXDEN_RST;
            r_tol     <= TOL_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_MAX_DEN: r_max_den <= i_pwdata[MAXDEN_W-1:0];
                REG_TOL:     r_tol     <= i_pwdata[TOL_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_MAX_DEN: o_prdata = APB_DW'(r_max_den);
            REG_TOL:     o_prdata = APB_DW'(r_tol);
            default:     o_prdata = '0;
        endcase
    end

    assign o_pready  = 1'b1;
    assign o_max_den = r_max_den;
    assign o_tol     = r_tol;

endmodule

// ===== rtl/core/bra_ctrl.sv =====
// Sequencing state machine of the rational approximation block.
module bra_ctrl
    import bra_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    o_busy,
    output logic    o_valid
);

    t_state r_state;
    t_state n_state;
    logic   r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == ST_EMIT);
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_start) n_state = ST_SPLIT;
            ST_SPLIT: n_state = ST_INIT;
            ST_INIT:  n_state = ST_WALK;
            ST_WALK:  if (!i_sts.in_bounds || i_sts.hit) n_state = ST_MULT;
            ST_MULT:  n_state = ST_ADD;
            ST_ADD:   n_state = ST_EMIT;
            ST_EMIT:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_IDLE:  o_cmd.capture = i_start;
            ST_SPLIT: o_cmd.split   = 1'b1;
            ST_INIT:  o_cmd.init    = 1'b1;
            ST_WALK: begin
                if (!i_sts.in_bounds || i_sts.hit) begin
                    o_cmd.pick = 1'b1;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            ST_MULT:  o_cmd.mult    = 1'b1;
            ST_ADD:   o_cmd.add_int = 1'b1;
            ST_EMIT:  o_cmd.emit    = 1'b1;
            default:  o_cmd = '0;
        endcase
    end

    assign o_busy  = (r_state != ST_IDLE);
    assign o_valid = r_valid;

endmodule

// ===== rtl/core/bra_dp.sv =====
// Datapath: sign strip, integer split, mediant walk and result rebuild.
module bra_dp
    import bra_pkg::*;
#(
    parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF,
    parameter int unsigned INT_BITS   = INT_BITS_DEF,
    parameter int unsigned DENOM_BITS = DENOM_BITS_DEF
) (
    input  logic                          i_clk,
    input  t_dp_cmd                       i_cmd,
    input  logic signed [INT_BITS+FRAC_BITS:0] i_x_value,
    input  logic [MAXDEN_W-1:0]           i_max_den,
    input  logic [TOL_W-1:0]              i_tol,
    output t_dp_sts                       o_sts,
    output logic signed [NUM_W-1:0]       o_numerator,
    output logic [DENOM_BITS-1:0]         o_denominator
);

    localparam int unsigned XW = 1 + INT_BITS + FRAC_BITS;
    localparam int unsigned WW = INT_BITS + 1;
    localparam int unsigned FW = FRAC_BITS + 1;
    localparam int unsigned QW = DENOM_BITS + 1;
    localparam int unsigned EW = ((FRAC_BITS > TOL_W) ? FRAC_BITS : TOL_W) + DENOM_BITS + 5;
    localparam int unsigned PW = WW + DENOM_BITS;
    localparam int unsigned NW = PW + 1;
    localparam int unsigned SW = (NW > NUM_W) ? NW : NUM_W;

    localparam logic [XW-1:0] X_ONE = {{(XW-1){1'b0}}, 1'b1} << FRAC_BITS;
    localparam logic [EW-1:0] E_ONE = {{(EW-1){1'b0}}, 1'b1} << FRAC_BITS;

    logic                    r_neg;
    logic [XW-1:0]           r_mag;
    logic [WW-1:0]           r_whole;
    logic [FW-1:0]           r_frac;
    logic [DENOM_BITS-1:0]   r_lim;
    logic [QW-1:0]           r_a, r_b, r_c, r_d;
    logic signed [EW-1:0]    r_eab, r_ecd, r_uab, r_ucd, r_vab, r_vcd;
    logic [DENOM_BITS-1:0]   r_rn, r_rd;
    logic [PW-1:0]           r_prod;
    logic [NUM_W-2:0]        r_nmag;
    logic signed [NUM_W-1:0] r_num;
    logic [DENOM_BITS-1:0]   r_den;

    logic [XW-1:0]           w_x;
    logic [DENOM_BITS+MAXDEN_W-1:0] w_md_ext;
    logic [DENOM_BITS-1:0]   w_lim;
    logic [QW-1:0]           w_lim_q;
    logic [QW-1:0]           w_p, w_q;
    logic signed [EW-1:0]    w_fe, w_te;
    logic signed [EW-1:0]    w_se, w_su, w_sv;
    logic                    w_gt;
    logic                    w_in_bounds;
    logic                    w_hit;
    logic [SW-1:0]           w_nsum;

    assign w_x      = i_x_value;
    assign w_md_ext = {{DENOM_BITS{1'b0}}, i_max_den};

    // A zero bound behaves as a bound of one.
    always_comb begin
        w_lim = w_md_ext[DENOM_BITS-1:0];
        if (w_lim == '0) begin
            w_lim = {{(DENOM_BITS-1){1'b0}}, 1'b1};
        end
    end

    assign w_lim_q = {1'b0, r_lim};
    assign w_p     = r_a + r_c;
    assign w_q     = r_b + r_d;
    assign w_fe    = $signed(EW'(r_frac));
    assign w_te    = $signed(EW'(i_tol));

    // Each bracket carries its error e = f*den - num*2^F, and e -/+ tol*den.
    // The mediant's values are plain sums, so no multiplier sits in the loop.
    assign w_se = r_eab + r_ecd;
    assign w_su = r_uab + r_ucd;
    assign w_sv = r_vab + r_vcd;

    assign w_gt        = !w_se[EW-1] && (w_se != '0);
    assign w_hit       = w_su[EW-1] && !w_sv[EW-1] && (w_sv != '0);
    assign w_in_bounds = (r_b <= w_lim_q) && (r_d <= w_lim_q);

    assign w_nsum = SW'(r_prod) + SW'(r_rn);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_neg <= w_x[XW-1];
            r_mag <= w_x[XW-1] ? (~w_x + {{(XW-1){1'b0}}, 1'b1}) : w_x;
        end

        if (i_cmd.split) begin
            r_lim <= w_lim;
            if (r_mag > X_ONE) begin
                r_whole <= r_mag[XW-1:FRAC_BITS];
                r_frac  <= {1'b0, r_mag[FRAC_BITS-1:0]};
            end else begin
                r_whole <= '0;
                r_frac  <= r_mag[FRAC_BITS:0];
            end
        end

        if (i_cmd.init) begin
            r_a   <= '0;
            r_b   <= {{(QW-1){1'b0}}, 1'b1};
            r_c   <= {{(QW-1){1'b0}}, 1'b1};
            r_d   <= {{(QW-1){1'b0}}, 1'b1};
            r_eab <= w_fe;
            r_uab <= w_fe - w_te;
            r_vab <= w_fe + w_te;
            r_ecd <= w_fe - $signed(E_ONE);
            r_ucd <= w_fe - $signed(E_ONE) - w_te;
            r_vcd <= w_fe - $signed(E_ONE) + w_te;
        end

        if (i_cmd.step) begin
            if (w_gt) begin
                r_a   <= w_p;
                r_b   <= w_q;
                r_eab <= w_se;
                r_uab <= w_su;
                r_vab <= w_sv;
            end else begin
                r_c   <= w_p;
                r_d   <= w_q;
                r_ecd <= w_se;
                r_ucd <= w_su;
                r_vcd <= w_sv;
            end
        end

        // Every candidate denominator here is at most the bound.
        if (i_cmd.pick) begin
            if (!w_in_bounds) begin
                if (r_b > w_lim_q) begin
                    r_rn <= r_c[DENOM_BITS-1:0];
                    r_rd <= r_d[DENOM_BITS-1:0];
                end else begin
                    r_rn <= r_a[DENOM_BITS-1:0];
                    r_rd <= r_b[DENOM_BITS-1:0];
                end
            end else if (w_q <= w_lim_q) begin
                r_rn <= w_p[DENOM_BITS-1:0];
                r_rd <= w_q[DENOM_BITS-1:0];
            end else if (r_d > r_b) begin
                r_rn <= r_c[DENOM_BITS-1:0];
                r_rd <= r_d[DENOM_BITS-1:0];
            end else begin
                r_rn <= r_a[DENOM_BITS-1:0];
                r_rd <= r_b[DENOM_BITS-1:0];
            end
        end

        if (i_cmd.mult) begin
            r_prod <= PW'(r_whole) * PW'(r_rd);
        end

        if (i_cmd.add_int) begin
            if (w_nsum > SW'(NUM_MAX)) begin
                r_nmag <= NUM_MAX[NUM_W-2:0];
            end else begin
                r_nmag <= w_nsum[NUM_W-2:0];
            end
        end

        if (i_cmd.emit) begin
            r_num <= r_neg ? $signed(NUM_W'(0) - {1'b0, r_nmag}) : $signed({1'b0, r_nmag});
            r_den <= r_rd;
        end
    end

    assign o_sts.in_bounds = w_in_bounds;
    assign o_sts.hit       = w_hit;
    assign o_numerator     = r_num;
    assign o_denominator   = r_den;

endmodule

// ===== rtl/core/best_rational_approximation.sv =====
// Top level of the best rational approximation block.
//
// The block takes a signed fixed-point word (Q15.32 by default) and returns the
// fraction numerator/denominator that approximates it, with the denominator no
// larger than the max_denominator register (a value of zero acts as one). A word
// is taken at a rising edge where start is high and busy is low. The sign is
// stripped, and the integer part is split off only when the magnitude is above
// one. The fractional part is then located in the Stern-Brocot tree by one
// mediant step per clock cycle; a mediant is a hit once it lies closer than the
// tolerance register (in units of 2^-FRAC_BITS) to the input. Each bracket keeps
// its error terms as running sums, so the per-step test is three wide additions
// and sign checks with no multiplier or divider in the loop. After the walk the
// integer part is multiplied back in, the numerator magnitude saturates at
// 2147483647 and the sign is applied. Every tree step adds a bracket whose
// denominator is larger than the step count, so a word walks at most
// max_denominator steps (one step for a zero bound). Only one word is in
// flight; busy drops in the cycle the result appears, so the next start may
// be given then. The result sits on o_numerator and o_denominator for
// exactly one cycle, marked by o_valid, and the receiver cannot hold it off. The
// configuration registers (max_denominator at byte address 0, tolerance at 4)
// should only be written while busy is low.
module best_rational_approximation
    import bra_pkg::*;
#(
    parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF,
    parameter int unsigned INT_BITS   = INT_BITS_DEF,
    parameter int unsigned DENOM_BITS = DENOM_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [INT_BITS+FRAC_BITS:0] i_x_value,
    output logic                               o_valid,
    output logic signed [NUM_W-1:0]            o_numerator,
    output logic [DENOM_BITS-1:0]              o_denominator,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [APB_AW-1:0]                  paddr,
    input  logic [APB_DW-1:0]                  pwdata,
    output logic [APB_DW-1:0]                  prdata,
    output logic                               pready
);

    logic [MAXDEN_W-1:0] w_max_den;
    logic [TOL_W-1:0]    w_tol;
    t_dp_cmd             w_cmd;
    t_dp_sts             w_sts;

    // Register file: both registers are read directly by the datapath.
    bra_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_max_den (w_max_den),
        .o_tol     (w_tol)
    );

    // The controller walks through split, initialise, tree walk and rebuild.
    bra_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    // The datapath holds the word, the brackets and the result registers.
    bra_dp #(
        .FRAC_BITS  (FRAC_BITS),
        .INT_BITS   (INT_BITS),
        .DENOM_BITS (DENOM_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_cmd         (w_cmd),
        .i_x_value     (i_x_value),
        .i_max_den     (w_max_den),
        .i_tol         (w_tol),
        .o_sts         (w_sts),
        .o_numerator   (o_numerator),
        .o_denominator (o_denominator)
    );

endmodule

// ===== rtl/core/bra_checker.sv =====
// Port-level checker of the rational approximation block, bound to the top level.
`include "best_rational_approximation_assert.svh"

module bra_checker #(
    parameter int unsigned DENOM_BITS = 16
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  o_valid,
    input logic [DENOM_BITS-1:0] o_denominator
);

    // A result only appears once the block has finished with the word.
    `BRA_ASSERT_IMPLY(a_valid_idle, i_clk, i_rst_n, o_valid, !busy, "result shown while busy")

    // Each word gives a single one-cycle result.
    `BRA_ASSERT(a_valid_pulse, i_clk, i_rst_n, o_valid |=> !o_valid, "result held for two cycles")

    // An accepted word makes the block busy.
    `BRA_ASSERT(a_accept_busy, i_clk, i_rst_n, (start && !busy) |=> busy, "accepted word lost")

    // Leaving busy outside reset always delivers the result.
    `BRA_ASSERT_IMPLY(a_end_result, i_clk, i_rst_n, $fell(busy) && $past(i_rst_n), o_valid, "no result at end of work")

    // A result never carries a zero denominator.
    `BRA_ASSERT_IMPLY(a_den_nonzero, i_clk, i_rst_n, o_valid, o_denominator != '0, "zero denominator")

endmodule

bind best_rational_approximation bra_checker #(.DENOM_BITS(DENOM_BITS)) u_bra_checker (.*);

// ===== tb/sv/tb_best_rational_approximation.sv =====
// Self-checking testbench of the best rational approximation block.
module tb_best_rational_approximation;
    import bra_pkg::*;

    // Width of the input word and of the result denominator at the default geometry.
    localparam int XW = 1 + INT_BITS_DEF + FRAC_BITS_DEF;
    localparam int DW = DENOM_BITS_DEF;

    // A word walks at most max_denominator steps, so the limit leaves a wide margin
    // over the run even if every word of the run walked the full widest bound.
    localparam int unsigned CYCLE_LIMIT = 40_000_000;
    // A short tail is enough to catch a stray result.
    localparam int TAIL_CYCLES = 16;
    localparam int N_PHASES    = 12;
    localparam int PHASE_WORDS = 50;
    // Phases at the widest bound are kept short, since each word may walk far.
    localparam int WIDE_WORDS  = 8;

    typedef struct packed {
        logic signed [NUM_W-1:0] num;
        logic [DW-1:0]           den;
    } fraction_t;

    // One row of the directed table: the register setting it runs under, the
    // word itself, and an expected fraction where one can be read off directly.
    typedef struct packed {
        logic [MAXDEN_W-1:0]     maxden;
        logic [TOL_W-1:0]        tol;
        logic [XW-1:0]           x;
        logic                    known;
        logic signed [NUM_W-1:0] num;
        logic [DW-1:0]           den;
    } dir_row_t;

    localparam int N_DIR = 23;
    localparam dir_row_t DIR_ROWS [N_DIR] = '{
        // Reset setting: zero, plus and minus one, halves, an integer part,
        // both ends of the input range, one LSB either side of zero, pi and -0.7.
        '{MAXDEN_RST, TOL_RST, 48'h0000_0000_0000, 1'b1, 32'sd0,      16'd1},
        '{MAXDEN_RST, TOL_RST, 48'h0001_0000_0000, 1'b1, 32'sd1,      16'd1},
        '{MAXDEN_RST, TOL_RST, 48'hFFFF_0000_0000, 1'b1, -32'sd1,     16'd1},
        '{MAXDEN_RST, TOL_RST, 48'h0000_8000_0000, 1'b1, 32'sd1,      16'd2},
        '{MAXDEN_RST, TOL_RST, 48'hFFFF_8000_0000, 1'b1, -32'sd1,     16'd2},
        '{MAXDEN_RST, TOL_RST, 48'h0002_8000_0000, 1'b1, 32'sd5,      16'd2},
        '{MAXDEN_RST, TOL_RST, 48'h7FFF_FFFF_FFFF, 1'b1, 32'sd32768,  16'd1},
        '{MAXDEN_RST, TOL_RST, 48'h8000_0000_0000, 1'b1, -32'sd32768, 16'd1},
        '{MAXDEN_RST, TOL_RST, 48'hFFFF_FFFF_FFFF, 1'b1, 32'sd0,      16'd1},
        '{MAXDEN_RST, TOL_RST, 48'h0000_0000_0001, 1'b1, 32'sd0,      16'd1},
        '{MAXDEN_RST, TOL_RST, 48'h0003_243F_6A89, 1'b0, 32'sd0,      16'd0},
        '{MAXDEN_RST, TOL_RST, 48'hFFFF_4CCC_CCCD, 1'b0, 32'sd0,      16'd0},
        // A zero bound acts as one: a hit on one half falls back to the lower bracket.
        '{16'd0,      TOL_RST, 48'h0000_8000_0000, 1'b1, 32'sd0,      16'd1},
        '{16'd0,      TOL_RST, 48'hFFFD_4000_0000, 1'b0, 32'sd0,      16'd0},
        '{16'd1,      TOL_RST, 48'h0000_C000_0000, 1'b0, 32'sd0,      16'd0},
        // Largest tolerance: the first mediant is always a hit.
        '{16'd16,     '1,      48'h0000_4CCC_CCCD, 1'b0, 32'sd0,      16'd0},
        '{16'd16,     '1,      48'hFFF8_1999_999A, 1'b0, 32'sd0,      16'd0},
        '{16'd16,     '1,      48'h0000_0000_0000, 1'b0, 32'sd0,      16'd0},
        // Widest bound, mostly with zero tolerance: walks that run all the way to the bound,
        // and the largest numerator the input range allows.
        '{16'hFFFF,   '0,      48'h0000_0000_0001, 1'b1, 32'sd0,      16'd1},
        '{16'hFFFF,   '0,      48'h0000_FFFF_FFFF, 1'b1, 32'sd1,      16'd1},
        '{16'hFFFF,   '0,      48'h7FFF_FFFF_0000, 1'b0, 32'sd0,      16'd0},
        '{16'hFFFF,   '0,      48'hFFFC_DBC0_9577, 1'b0, 32'sd0,      16'd0},
        '{16'hFFFF,   TOL_RST, 48'h0000_5555_5555, 1'b0, 32'sd0,      16'd0}
    };

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic signed [XW-1:0]    i_x_value;
    logic                    o_valid;
    logic signed [NUM_W-1:0] o_numerator;
    logic [DW-1:0]           o_denominator;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [APB_AW-1:0]       paddr;
    logic [APB_DW-1:0]       pwdata;
    logic [APB_DW-1:0]       prdata;
    logic                    pready;

    // The testbench's own copy of the two registers, used by the predictor.
    logic [MAXDEN_W-1:0] max_den_cfg;
    logic [TOL_W-1:0]    tol_cfg;

    // Fractions still owed by the block, oldest first.
    fraction_t   pending_fracs [$];
    int          fail_count;
    int          words_sent;
    int          results_seen;
    int          settings_used;
    int unsigned cycle_count;

    best_rational_approximation dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_x_value     (i_x_value),
        .o_valid       (o_valid),
        .o_numerator   (o_numerator),
        .o_denominator (o_denominator),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Predicts the fraction for one word under the current register copy. The
    // fractional part is placed in the Stern-Brocot tree by mediants; the hit test
    // is done cross-multiplied, so every quantity stays an exact integer. The
    // products reach about 2^49 at most, which 64 bits hold comfortably.
    function automatic fraction_t approx_fraction(logic signed [XW-1:0] x);
        logic          neg;
        logic [XW-1:0] mag;
        logic [63:0]   one, whole, frac, lim;
        logic [63:0]   a, b, c, d, p, q, lhs, rhs, gap, rn, rd, nmag;
        logic          settled;
        fraction_t     res;
        one   = 64'd1 << FRAC_BITS_DEF;
        neg   = x[XW-1];
        mag   = neg ? (~x + 1'b1) : x;
        whole = '0;
        frac  = 64'(mag);
        lim   = 64'(max_den_cfg);
        if (lim == 0) begin
            lim = 1;
        end
        // The integer part comes off only when the magnitude is strictly above one;
        // exactly one walks as a fraction of one and lands on 1/1.
        if (64'(mag) > one) begin
            whole = 64'(mag) >> FRAC_BITS_DEF;
            frac  = 64'(mag) & (one - 1);
        end
        a = 0; b = 1; c = 1; d = 1;
        rn = 0; rd = 1;
        settled = 1'b0;
        while (!settled && b <= lim && d <= lim) begin
            p   = a + c;
            q   = b + d;
            lhs = frac * q;
            rhs = p << FRAC_BITS_DEF;
            gap = (lhs > rhs) ? lhs - rhs : rhs - lhs;
            if (gap < 64'(tol_cfg) * q) begin
                // A hit past the bound falls back to the bracket with the larger
                // denominator, the lower one on a tie.
                if (q <= lim) begin
                    rn = p; rd = q;
                end else if (d > b) begin
                    rn = c; rd = d;
                end else begin
                    rn = a; rd = b;
                end
                settled = 1'b1;
            end else if (lhs > rhs) begin
                a = p; b = q;
            end else begin
                c = p; d = q;
            end
        end
        if (!settled) begin
            if (b > lim) begin
                rn = c; rd = d;
            end else begin
                rn = a; rd = b;
            end
        end
        nmag = rn + whole * rd;
        if (nmag > 64'(NUM_MAX)) begin
            nmag = 64'(NUM_MAX);
        end
        // A negative word with a zero numerator still gives a plain zero.
        res.num = neg ? -nmag[NUM_W-1:0] : nmag[NUM_W-1:0];
        res.den = rd[DW-1:0];
        return res;
    endfunction

    // Draws one random word. Most shapes aim at the interesting corners: values
    // near zero and one, near integers, and near simple fractions, where the walk
    // either runs long or hits early. Walks that could run to a very wide bound
    // are kept to full-range values so that a phase stays short.
    function automatic logic signed [XW-1:0] random_x(bit slow_ok);
        logic [XW-1:0] v;
        logic [63:0]   fr;
        int            m;
        int            kind;
        kind = slow_ok ? int'($urandom_range(0, 5)) : (($urandom_range(0, 1) == 0) ? 0 : 5);
        case (kind)
            0: begin
                v = XW'({$urandom, $urandom});
            end
            1: begin
                v = XW'({1'($urandom_range(0, 1)), $urandom});
            end
            2: begin
                v = (XW'($urandom_range(0, 32767)) << FRAC_BITS_DEF)
                    + XW'($urandom_range(0, 8)) - XW'(4);
            end
            3: begin
                m  = int'($urandom_range(1, 300));
                fr = (64'($urandom_range(0, m)) << FRAC_BITS_DEF) / 64'(m);
                v  = (XW'($urandom_range(0, 7)) << FRAC_BITS_DEF) + XW'(fr);
            end
            4: begin
                v = XW'($urandom_range(0, 4095));
            end
            default: begin
                v = (XW'($urandom_range(16384, 32767)) << FRAC_BITS_DEF) + XW'($urandom);
            end
        endcase
        if (kind != 0 && $urandom_range(0, 1) == 1) begin
            v = ~v + 1'b1;
        end
        return v;
    endfunction

    // Offers one word and holds it until the block takes it, then books the
    // fraction that it is owed.
    task automatic send_word(logic signed [XW-1:0] x, fraction_t want);
        start     <= 1'b1;
        i_x_value <= x;
        do @(posedge i_clk); while (busy);
        pending_fracs.push_back(want);
        words_sent++;
    endtask

    // Drops start for a random burst, with the given chance in percent.
    task automatic idle_gap(int pct);
        if (pct != 0 && $urandom_range(0, 99) < pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // Stops offering words and waits until every owed fraction has arrived.
    task automatic drain();
        start <= 1'b0;
        while (pending_fracs.size() != 0 || busy) @(posedge i_clk);
    endtask

    // Writes one register, then reads it straight back over the same port.
    task automatic write_reg(t_reg_idx idx, logic [APB_DW-1:0] val);
        logic [APB_DW-1:0] mask;
        logic [APB_DW-1:0] got;
        mask = (idx == REG_MAX_DEN) ? APB_DW'({MAXDEN_W{1'b1}}) : '1;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(int'(idx) * 4);
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        // Straight into the setup cycle of the read-back.
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        // The port goes idle before the next transfer.
        @(posedge i_clk);
        if ((got & mask) !== (val & mask)) begin
            $error("register %s: expected %0d, got %0d", idx.name(), val & mask, got & mask);
            fail_count++;
        end
        if (idx == REG_MAX_DEN) begin
            max_den_cfg = val[MAXDEN_W-1:0];
        end else begin
            tol_cfg = val[TOL_W-1:0];
        end
    endtask

    // Registers are only touched once the block has gone quiet.
    task automatic apply_config(logic [MAXDEN_W-1:0] maxden, logic [TOL_W-1:0] tol);
        drain();
        write_reg(REG_MAX_DEN, APB_DW'(maxden));
        write_reg(REG_TOL, APB_DW'(tol));
        settings_used++;
    endtask

    // Results cannot be held off, so each one is checked in the cycle it shows,
    // against the oldest fraction still owed.
    always @(posedge i_clk) begin : check_results
        fraction_t want;
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (pending_fracs.size() == 0) begin
                $error("result %0d/%0d with no word outstanding", o_numerator, o_denominator);
                fail_count++;
            end else begin
                want = pending_fracs.pop_front();
                if (o_numerator !== want.num) begin
                    $error("numerator: expected %0d, got %0d", want.num, o_numerator);
                    fail_count++;
                end
                if (o_denominator !== want.den) begin
                    $error("denominator: expected %0d, got %0d", want.den, o_denominator);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_best_rational_approximation: done, errors");
            $finish;
        end
    end

    initial begin : stimulus
        dir_row_t            row;
        fraction_t           want;
        logic signed [XW-1:0] x;
        logic [MAXDEN_W-1:0] maxden;
        logic [TOL_W-1:0]    tol;
        int                  n_words;
        int                  idle_pct;
        fail_count    = 0;
        words_sent    = 0;
        results_seen  = 0;
        settings_used = 1;
        cycle_count   = 0;
        max_den_cfg   = MAXDEN_RST;
        tol_cfg       = TOL_RST;

        i_rst_n   <= 1'b0;
        start     <= 1'b0;
        i_x_value <= '0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table. The first rows run on the reset values of the registers,
        // so they also prove that reset loaded them.
        for (int i = 0; i < N_DIR; i++) begin
            row = DIR_ROWS[i];
            if (row.maxden != max_den_cfg || row.tol != tol_cfg) begin
                apply_config(row.maxden, row.tol);
            end
            want = row.known ? fraction_t'({row.num, row.den}) : approx_fraction(row.x);
            send_word(row.x, want);
            idle_gap(20);
        end

        // Random phases, each under a fresh register setting. The bound is mostly
        // small so that walks stay short, with the occasional zero, one or widest
        // value; the tolerance swings between zero, small, random and all ones.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            case ($urandom_range(0, 9))
                0:       maxden = '0;
                1:       maxden = 16'd1;
                2:       maxden = '1;
                default: maxden = MAXDEN_W'($urandom_range(2, 300));
            endcase
            case ($urandom_range(0, 3))
                0:       tol = '0;
                1:       tol = TOL_W'($urandom_range(0, 20000));
                2:       tol = $urandom;
                default: tol = '1;
            endcase
            apply_config(maxden, tol);
            n_words = (maxden > 16'd300) ? WIDE_WORDS : PHASE_WORDS;
            // Some phases run back to back; the last one never idles.
            case ($urandom_range(0, 2))
                0:       idle_pct = 0;
                1:       idle_pct = 15;
                default: idle_pct = 40;
            endcase
            if (ph == N_PHASES - 1) begin
                idle_pct = 0;
            end
            for (int k = 0; k < n_words; k++) begin
                x = random_x(maxden <= 16'd300);
                send_word(x, approx_fraction(x));
                idle_gap(idle_pct);
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Run covered %0d words (%0d from the directed table) and %0d results,",
                 words_sent, N_DIR, results_seen);
        $display("under %0d register settings including bounds of zero, one and 65535.",
                 settings_used);
        if (fail_count == 0) begin
            $display("tb_best_rational_approximation: done, clean");
        end else begin
            $display("tb_best_rational_approximation: done, errors");
        end
        $finish;
    end

endmodule
